// ===== src/assert_macros.svh =====
// Assertion helpers used by the RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Assert a property at every clock edge outside reset
`define ASSERT_CLK(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Assert a property at every clock edge, reset included
`define ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ===== src/frq_pkg.sv =====
`default_nettype none
package frq_pkg;
  localparam int QueueDepth = 16;
  localparam int TableSlots = 16;
  localparam int SlotW = 4;
  localparam int CountW = 5;

  localparam logic [2:0] CMD_INSTALL = 3'd0;
  localparam logic [2:0] CMD_ENQUEUE = 3'd1;
  localparam logic [2:0] CMD_REMOVE = 3'd2;
  localparam logic [2:0] CMD_BLOCK = 3'd3;
  localparam logic [2:0] CMD_CHILD = 3'd4;
  localparam logic [2:0] CMD_PIPE = 3'd5;
  localparam logic [2:0] CMD_EXIT = 3'd6;

  localparam logic [1:0] RS_IDLE = 2'd0;
  localparam logic [1:0] RS_RUNNABLE = 2'd1;
  localparam logic [1:0] RS_RUNNING = 2'd2;
  localparam logic [1:0] RS_BLOCKED = 2'd3;

  localparam logic [1:0] WR_NONE = 2'd0;
  localparam logic [1:0] WR_CHILD = 2'd1;
  localparam logic [1:0] WR_READ = 2'd2;
  localparam logic [1:0] WR_WRITE = 2'd3;

  localparam logic [2:0] ST_OK = 3'd0;
  localparam logic [2:0] ST_INVALID = 3'd1;
  localparam logic [2:0] ST_QUEUED = 3'd2;
  localparam logic [2:0] ST_FULL = 3'd3;
  localparam logic [2:0] ST_NONE = 3'd4;

  localparam logic [31:0] PID_ANY = 32'hFFFF_FFFF;

  // Controller to datapath
  typedef struct packed {
    logic latch;       // capture the request
    logic install;     // write the slot record
    logic push_req;    // enqueue the request slot
    logic scan_start;  // clear scan index and match flag
    logic scan_step;   // compare one queue entry, advance
    logic comp_step;   // compaction step for remove
    logic comp_done;   // commit compacted count
    logic pop_step;    // pop head entry
    logic block_cur;   // block current, make found running
    logic exit_none;   // drop current process
    logic tbl_start;   // clear table index
    logic tbl_step;    // check one table slot for wake
    logic set_status;  // load status
    logic [2:0] status;
  } frq_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic [2:0] command;
    logic slot_pid_zero;
    logic cur_present;
    logic [1:0] reason;
    logic queue_full;
    logic queue_empty;
    logic scan_end;
    logic scan_hit;
    logic head_runnable;
    logic tbl_end;
  } frq_stat_t;
endpackage
`default_nettype wire

// ===== src/fifo_ready_queue_with_wait_wakeup_unit.sv =====
// Channel   | Handshake              | Payload
// request   | in_valid / in_ready    | command slot pid block_reason pipe_id pipe_has_*
// result    | out_valid / out_ready  | status dispatched_* woken_count queue_length
//                                      current_valid
// One request at a time: install and refusals pass the accept, decode and result states.
// Enqueue and remove add a scan over the queue entries (S_SCAN, S_COMP);
// block and exit pop entries until a runnable one is found, then commit it;
// wakes check one table slot a cycle, then pass S_DONE. Result stalls hold S_OUT.
// A result holds until taken; the next request is accepted after that.
// Reset (rst, synchronous) clears the table, the queue count and the current process.
`default_nettype none
module fifo_ready_queue_with_wait_wakeup_unit import frq_pkg::*; (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic in_valid,
  output logic in_ready,
  input  wire logic [2:0] command,
  input  wire logic [3:0] slot,
  input  wire logic [31:0] pid,
  input  wire logic [1:0] block_reason,
  input  wire logic [7:0] pipe_id,
  input  wire logic pipe_has_data,
  input  wire logic pipe_has_writers,
  input  wire logic pipe_has_space,
  input  wire logic pipe_has_readers,
  output logic out_valid,
  input  wire logic out_ready,
  output logic [2:0] status,
  output logic dispatched_valid,
  output logic [3:0] dispatched_slot,
  output logic [4:0] woken_count,
  output logic [4:0] queue_length,
  output logic current_valid
);
  frq_cmd_t cmd;
  frq_stat_t stat;

  frq_ctrl u_ctrl (
    .clk, .rst, .in_valid, .in_ready, .out_valid, .out_ready, .stat, .cmd
  );

  frq_datapath u_dp (
    .clk, .rst, .cmd, .stat, .command, .slot, .pid, .block_reason, .pipe_id,
    .pipe_has_data, .pipe_has_writers, .pipe_has_space, .pipe_has_readers,
    .status, .dispatched_valid, .dispatched_slot, .woken_count, .queue_length,
    .current_valid
  );
endmodule
`default_nettype wire

// ===== src/frq_datapath.sv =====
`default_nettype none
module frq_datapath import frq_pkg::*; (
  input  wire logic clk,
  input  wire logic rst,
  input  wire frq_cmd_t cmd,
  output frq_stat_t stat,
  input  wire logic [2:0] command,
  input  wire logic [3:0] slot,
  input  wire logic [31:0] pid,
  input  wire logic [1:0] block_reason,
  input  wire logic [7:0] pipe_id,
  input  wire logic pipe_has_data,
  input  wire logic pipe_has_writers,
  input  wire logic pipe_has_space,
  input  wire logic pipe_has_readers,
  output logic [2:0] status,
  output logic dispatched_valid,
  output logic [3:0] dispatched_slot,
  output logic [4:0] woken_count,
  output logic [4:0] queue_length,
  output logic current_valid
);
  logic [31:0] slot_pid [TableSlots];
  logic [1:0] slot_run_state [TableSlots];
  logic [1:0] slot_wait_reason [TableSlots];
  logic [31:0] slot_wait_pid [TableSlots];
  logic [7:0] slot_wait_pipe [TableSlots];
  logic [SlotW-1:0] fifo [QueueDepth];
  logic [CountW-1:0] count;
  logic [SlotW-1:0] cur_slot;
  logic cur_present;

  logic [2:0] r_cmd;
  logic [SlotW-1:0] r_slot;
  logic [31:0] r_pid;
  logic [1:0] r_reason;
  logic [7:0] r_pipe;
  logic r_data, r_writers, r_space, r_readers;

  logic [CountW-1:0] idx;   // read index for scans
  logic [CountW-1:0] widx;  // write index for compaction
  logic hit;
  logic [SlotW-1:0] tidx;
  logic tbl_last;

  logic [SlotW-1:0] qe;
  logic [SlotW-1:0] head;
  logic wake_match;
  logic wake_ok;
  logic in_q;

  assign qe = fifo[idx[SlotW-1:0]];
  assign head = fifo[0];

  // Whether table slot tidx wakes on this request
  always_comb begin
    wake_match = 1'b0;
    if (slot_pid[tidx] != '0 && slot_run_state[tidx] == RS_BLOCKED) begin
      if (r_cmd == CMD_CHILD) begin
        wake_match = slot_wait_reason[tidx] == WR_CHILD &&
          (slot_wait_pid[tidx] == r_pid || slot_wait_pid[tidx] == PID_ANY);
      end else if (slot_wait_pipe[tidx] == r_pipe) begin
        if (slot_wait_reason[tidx] == WR_READ) begin
          wake_match = r_data || !r_writers;
        end else if (slot_wait_reason[tidx] == WR_WRITE) begin
          wake_match = r_space || !r_readers;
        end
      end
    end
  end

  // Queue membership of tidx, tested over all entries
  always_comb begin
    in_q = 1'b0;
    for (int i = 0; i < QueueDepth; i++) begin
      if (CountW'(i) < count && fifo[i] == tidx) in_q = 1'b1;
    end
  end

  assign wake_ok = wake_match && !in_q && count != CountW'(QueueDepth);
  assign tbl_last = tidx == SlotW'(TableSlots - 1);

  always_comb begin
    stat.command = r_cmd;
    stat.slot_pid_zero = slot_pid[r_slot] == '0;
    stat.cur_present = cur_present;
    stat.reason = r_reason;
    stat.queue_full = count == CountW'(QueueDepth);
    stat.queue_empty = count == '0;
    stat.scan_end = idx >= count;
    stat.scan_hit = hit;
    stat.head_runnable = slot_run_state[head] == RS_RUNNABLE;
    stat.tbl_end = tbl_last;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < TableSlots; i++) begin
        slot_pid[i] <= '0;
        slot_run_state[i] <= RS_IDLE;
        slot_wait_reason[i] <= WR_NONE;
        slot_wait_pid[i] <= '0;
        slot_wait_pipe[i] <= '0;
      end
      count <= '0;
      cur_slot <= '0;
      cur_present <= 1'b0;
      status <= ST_OK;
      dispatched_valid <= 1'b0;
      dispatched_slot <= '0;
      woken_count <= '0;
      idx <= '0;
      widx <= '0;
      hit <= 1'b0;
      tidx <= '0;
    end else begin
      // Capture request
      if (cmd.latch) begin
        r_cmd <= command;
        r_slot <= slot;
        r_pid <= pid;
        r_reason <= block_reason;
        r_pipe <= pipe_id;
        r_data <= pipe_has_data;
        r_writers <= pipe_has_writers;
        r_space <= pipe_has_space;
        r_readers <= pipe_has_readers;
        dispatched_valid <= 1'b0;
        dispatched_slot <= '0;
        woken_count <= '0;
        status <= ST_OK;
      end
      if (cmd.set_status) status <= cmd.status;
      if (cmd.install) begin
        slot_pid[r_slot] <= r_pid;
        slot_run_state[r_slot] <= RS_IDLE;
        slot_wait_reason[r_slot] <= WR_NONE;
        slot_wait_pid[r_slot] <= '0;
        slot_wait_pipe[r_slot] <= '0;
      end
      if (cmd.scan_start) begin
        idx <= '0;
        widx <= '0;
        hit <= 1'b0;
      end
      // Look for the request slot in the queue
      if (cmd.scan_step) begin
        if (qe == r_slot) hit <= 1'b1;
        idx <= idx + 1'b1;
      end
      if (cmd.push_req) begin
        slot_run_state[r_slot] <= RS_RUNNABLE;
        fifo[count[SlotW-1:0]] <= r_slot;
        count <= count + 1'b1;
      end
      // Compact queue, skipping copies of the request slot
      if (cmd.comp_step) begin
        if (qe != r_slot) begin
          fifo[widx[SlotW-1:0]] <= qe;
          widx <= widx + 1'b1;
        end
        idx <= idx + 1'b1;
      end
      if (cmd.comp_done) count <= widx;
      // Pop head: shift queue one place, remember a runnable head
      if (cmd.pop_step) begin
        for (int i = 0; i < QueueDepth - 1; i++) fifo[i] <= fifo[i+1];
        count <= count - 1'b1;
        if (slot_run_state[head] == RS_RUNNABLE) begin
          dispatched_valid <= 1'b1;
          dispatched_slot <= head;
        end
      end
      // Commit dispatch: block old current on a block request, run new one
      if (cmd.block_cur) begin
        if (r_cmd == CMD_BLOCK && cur_slot != dispatched_slot) begin
          slot_run_state[cur_slot] <= RS_BLOCKED;
          slot_wait_reason[cur_slot] <= r_reason;
          slot_wait_pid[cur_slot] <= r_pid;
          slot_wait_pipe[cur_slot] <= r_pipe;
        end
        slot_run_state[dispatched_slot] <= RS_RUNNING;
        slot_wait_reason[dispatched_slot] <= WR_NONE;
        slot_wait_pid[dispatched_slot] <= '0;
        slot_wait_pipe[dispatched_slot] <= '0;
        cur_slot <= dispatched_slot;
        cur_present <= 1'b1;
      end
      if (cmd.exit_none) begin
        cur_present <= 1'b0;
        cur_slot <= '0;
      end
      if (cmd.tbl_start) tidx <= '0;
      // Wake one table slot per cycle
      if (cmd.tbl_step) begin
        if (wake_ok) begin
          slot_run_state[tidx] <= RS_RUNNABLE;
          fifo[count[SlotW-1:0]] <= tidx;
          count <= count + 1'b1;
          woken_count <= woken_count + 1'b1;
        end
        if (!tbl_last) tidx <= tidx + 1'b1;
      end
    end
  end

  assign queue_length = count;
  assign current_valid = cur_present;
endmodule
`default_nettype wire

// ===== src/frq_ctrl.sv =====
`default_nettype none
`include "assert_macros.svh"
module frq_ctrl import frq_pkg::*; (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic in_valid,
  output logic in_ready,
  output logic out_valid,
  input  wire logic out_ready,
  input  wire frq_stat_t stat,
  output frq_cmd_t cmd
);
  typedef enum logic [8:0] {
    S_IDLE = 9'b000000001,
    S_DEC  = 9'b000000010,
    S_SCAN = 9'b000000100,
    S_COMP = 9'b000001000,
    S_POP  = 9'b000010000,
    S_COMMIT = 9'b000100000,
    S_WAKE = 9'b001000000,
    S_DONE = 9'b010000000,
    S_OUT  = 9'b100000000
  } state_t;

  state_t state, state_next;
  logic dispatched;

  assign in_ready = state == S_IDLE;
  assign out_valid = state == S_OUT;

  always_comb begin
    cmd = '0;
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.latch = 1'b1;
          state_next = S_DEC;
        end
      end
      // Decode the request
      S_DEC: begin
        state_next = S_OUT;
        cmd.scan_start = 1'b1;
        case (stat.command)
          CMD_INSTALL: cmd.install = 1'b1;
          CMD_ENQUEUE: begin
            if (stat.slot_pid_zero) begin
              cmd.set_status = 1'b1;
              cmd.status = ST_INVALID;
            end else begin
              state_next = S_SCAN;
            end
          end
          CMD_REMOVE: state_next = S_COMP;
          CMD_BLOCK: begin
            if (!stat.cur_present || stat.reason == WR_NONE) begin
              cmd.set_status = 1'b1;
              cmd.status = ST_INVALID;
            end else begin
              state_next = S_POP;
            end
          end
          CMD_CHILD, CMD_PIPE: begin
            cmd.tbl_start = 1'b1;
            state_next = S_WAKE;
          end
          CMD_EXIT: state_next = S_POP;
          default: begin
            cmd.set_status = 1'b1;
            cmd.status = ST_INVALID;
          end
        endcase
      end
      // Membership check for enqueue
      S_SCAN: begin
        if (stat.scan_end) begin
          state_next = S_OUT;
          if (stat.scan_hit) begin
            cmd.set_status = 1'b1;
            cmd.status = ST_QUEUED;
          end else if (stat.queue_full) begin
            cmd.set_status = 1'b1;
            cmd.status = ST_FULL;
          end else begin
            cmd.push_req = 1'b1;
          end
        end else begin
          cmd.scan_step = 1'b1;
        end
      end
      S_COMP: begin
        if (stat.scan_end) begin
          cmd.comp_done = 1'b1;
          state_next = S_OUT;
        end else begin
          cmd.comp_step = 1'b1;
        end
      end
      // Pop until a runnable entry appears
      S_POP: begin
        if (dispatched) begin
          state_next = S_COMMIT;
        end else if (stat.queue_empty) begin
          cmd.set_status = 1'b1;
          cmd.status = ST_NONE;
          cmd.exit_none = stat.command == CMD_EXIT;
          state_next = S_OUT;
        end else begin
          cmd.pop_step = 1'b1;
        end
      end
      S_COMMIT: begin
        cmd.block_cur = 1'b1;
        state_next = S_OUT;
      end
      S_WAKE: begin
        cmd.tbl_step = 1'b1;
        if (stat.tbl_end) state_next = S_DONE;
      end
      S_DONE: state_next = S_OUT;
      S_OUT: begin
        if (out_ready) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Track whether a pop has found a runnable entry
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      dispatched <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.latch) dispatched <= 1'b0;
      else if (cmd.pop_step && stat.head_runnable) dispatched <= 1'b1;
    end
  end

  `ASSERT_CLK(a_onehot, clk, rst, $onehot(state), "state not one-hot")
  `ASSERT_CLK(a_no_overlap, clk, rst, !(in_ready && out_valid), "accept while result pending")
  `ASSERT_CLK(a_pop_nonempty, clk, rst, cmd.pop_step |-> !stat.queue_empty, "pop of empty queue")
endmodule
`default_nettype wire
